// File: src/ppjr_pkg.sv
// Package for the photometric pose Jacobian row block.
// Holds widths, register codes and the request/response beat types.
// No dependencies.
package ppjr_pkg;

   // pyramid depth and the highest usable level
   localparam int LEVELS = 4;
   localparam logic [1:0] LVL_MAX = 2'(LEVELS - 1);

   // register file
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y = 1'b1;
   localparam logic [31:0] FOCAL_RESET = 32'd34406400;

   // datapath widths
   localparam int LANES = 6;      // six Jacobian entries
   localparam int TERMS = 2;      // gradient-u and gradient-v terms
   localparam int CHUNKS = 3;     // operand slices per product
   localparam int CW = 21;        // operand slice width
   localparam int MW = 47;        // |grad| * focal
   localparam int OW = CHUNKS * CW; // geometric operand, 63 bits
   localparam int PW = MW + CW;   // partial product
   localparam int NW = 112;       // signed numerator
   localparam int N2W = 114;      // 2*|num| + den
   localparam int DW = 66;        // Z^2 * 2^level
   localparam int D2W = DW + 1;   // 2 * den
   localparam int RW = 68;        // divider remainder
   localparam int QW = 32;        // quotient bits
   localparam int HW = N2W - QW;  // upper part of n2

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] grad_u;
      logic signed [15:0] grad_v;
      logic [1:0]         pyramid_level;
   } req_type;

   typedef struct packed {
      logic signed [31:0] jac_rot_x;
      logic signed [31:0] jac_rot_y;
      logic signed [31:0] jac_rot_z;
      logic signed [31:0] jac_trans_x;
      logic signed [31:0] jac_trans_y;
      logic signed [31:0] jac_trans_z;
      logic               bad_depth;
      logic               saturated;
   } rsp_type;

endpackage

// File: src/photometric_pose_jacobian_row.sv
// Photometric pose Jacobian row: one beat per cycle sustained while the output
// is not stalled.
// Stages: operand products, slice multiplies, term sums, then a 32-step
// restoring divider (one quotient bit per stage) and a saturating output register.
// Synchronous active-high reset clears valid bits and resets focal_x/focal_y.
// Depends on ppjr_pkg.
module photometric_pose_jacobian_row
   import ppjr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [31:0] focal_x_ff, focal_y_ff;
   logic adv;
   logic rsp_valid_ff;

   // pipeline moves whenever the output slot can take a beat
   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= FOCAL_RESET;
         focal_y_ff <= FOCAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FOCAL_X: focal_x_ff <= csr_wdata;
            CSR_FOCAL_Y: focal_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: magnitudes and base products
   logic [15:0] ugu, ugv, mgu, mgv;
   logic [31:0] ux, uy, mx, my;
   logic [30:0] mz;
   logic [47:0] pa, pb;
   logic [63:0] pxy, pxx, pyy, pxz, pyz, pzz;
   logic [1:0]  lvl_in;

   always_comb begin
      ugu = req_data.grad_u;
      ugv = req_data.grad_v;
      ux = req_data.point_x;
      uy = req_data.point_y;
      mgu = ugu[15] ? (~ugu + 16'd1) : ugu;
      mgv = ugv[15] ? (~ugv + 16'd1) : ugv;
      mx = ux[31] ? (~ux + 32'd1) : ux;
      my = uy[31] ? (~uy + 32'd1) : uy;
      mz = req_data.point_z[30:0];
      pa = 48'(mgu) * 48'(focal_x_ff);
      pb = 48'(mgv) * 48'(focal_y_ff);
      pxy = 64'(mx) * 64'(my);
      pxx = 64'(mx) * 64'(mx);
      pyy = 64'(my) * 64'(my);
      pxz = 64'(mx) * 64'(mz);
      pyz = 64'(my) * 64'(mz);
      pzz = 64'(mz) * 64'(mz);
      lvl_in = (req_data.pyramid_level > LVL_MAX) ? LVL_MAX : req_data.pyramid_level;
   end

   logic          s1_vld_ff, s1_bad_ff, s1_na_ff, s1_nb_ff, s1_nx_ff, s1_ny_ff;
   logic [MW-1:0] s1_ma_ff, s1_mb_ff;
   logic [62:0]   s1_xy_ff, s1_xx_ff, s1_yy_ff;
   logic [62:0]   s1_xz_ff, s1_yz_ff;
   logic [61:0]   s1_zz_ff;
   logic [31:0]   s1_mx_ff, s1_my_ff;
   logic [30:0]   s1_mz_ff;
   logic [1:0]    s1_lvl_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bad_ff <= req_data.point_z[31] || (req_data.point_z == 32'sd0);
         s1_na_ff <= ugu[15];
         s1_nb_ff <= ugv[15];
         s1_nx_ff <= ux[31];
         s1_ny_ff <= uy[31];
         s1_ma_ff <= pa[MW-1:0];
         s1_mb_ff <= pb[MW-1:0];
         s1_xy_ff <= pxy[62:0];
         s1_xx_ff <= pxx[62:0];
         s1_yy_ff <= pyy[62:0];
         s1_xz_ff <= pxz[62:0];
         s1_yz_ff <= pyz[62:0];
         s1_zz_ff <= pzz[61:0];
         s1_mx_ff <= mx;
         s1_my_ff <= my;
         s1_mz_ff <= mz;
         s1_lvl_ff <= lvl_in;
      end
   end

   // ---------------- stage 2: operands and signs per term
   logic [OW-1:0] s2_op_in [LANES][TERMS];
   logic          s2_sg_in [LANES][TERMS];
   logic [DW-1:0] s2_den_in;

   always_comb begin
      s2_op_in[0][0] = OW'(s1_xy_ff);
      s2_op_in[0][1] = OW'(s1_zz_ff) + OW'(s1_yy_ff);
      s2_op_in[1][0] = OW'(s1_zz_ff) + OW'(s1_xx_ff);
      s2_op_in[1][1] = OW'(s1_xy_ff);
      s2_op_in[2][0] = OW'(s1_yz_ff);
      s2_op_in[2][1] = OW'(s1_xz_ff);
      s2_op_in[3][0] = OW'({s1_mz_ff, 16'd0});
      s2_op_in[3][1] = '0;
      s2_op_in[4][0] = '0;
      s2_op_in[4][1] = OW'({s1_mz_ff, 16'd0});
      s2_op_in[5][0] = OW'({s1_mx_ff, 16'd0});
      s2_op_in[5][1] = OW'({s1_my_ff, 16'd0});
      s2_sg_in[0][0] = !(s1_na_ff ^ s1_nx_ff ^ s1_ny_ff);
      s2_sg_in[0][1] = !s1_nb_ff;
      s2_sg_in[1][0] = s1_na_ff;
      s2_sg_in[1][1] = s1_nb_ff ^ s1_nx_ff ^ s1_ny_ff;
      s2_sg_in[2][0] = !(s1_na_ff ^ s1_ny_ff);
      s2_sg_in[2][1] = s1_nb_ff ^ s1_nx_ff;
      s2_sg_in[3][0] = s1_na_ff;
      s2_sg_in[3][1] = 1'b0;
      s2_sg_in[4][0] = 1'b0;
      s2_sg_in[4][1] = s1_nb_ff;
      s2_sg_in[5][0] = !(s1_na_ff ^ s1_nx_ff);
      s2_sg_in[5][1] = !(s1_nb_ff ^ s1_ny_ff);
      s2_den_in = DW'(s1_zz_ff) << s1_lvl_ff;
   end

   logic          s2_vld_ff, s2_bad_ff;
   logic [OW-1:0] s2_op_ff [LANES][TERMS];
   logic          s2_sg_ff [LANES][TERMS];
   logic [DW-1:0] s2_den_ff;
   logic [MW-1:0] s2_ma_ff, s2_mb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_bad_ff <= s1_bad_ff;
         s2_op_ff <= s2_op_in;
         s2_sg_ff <= s2_sg_in;
         s2_den_ff <= s2_den_in;
         s2_ma_ff <= s1_ma_ff;
         s2_mb_ff <= s1_mb_ff;
      end
   end

   // ---------------- stage 3: slice partial products
   logic [PW-1:0] s3_pp_in [LANES][TERMS][CHUNKS];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int t = 0; t < TERMS; t++) begin
            for (int c = 0; c < CHUNKS; c++) begin
               s3_pp_in[l][t][c] = PW'((t == 0) ? s2_ma_ff : s2_mb_ff)
                                 * PW'(s2_op_ff[l][t][c*CW +: CW]);
            end
         end
      end
   end

   logic          s3_vld_ff, s3_bad_ff;
   logic [PW-1:0] s3_pp_ff [LANES][TERMS][CHUNKS];
   logic          s3_sg_ff [LANES][TERMS];
   logic [DW-1:0] s3_den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_bad_ff <= s2_bad_ff;
         s3_pp_ff <= s3_pp_in;
         s3_sg_ff <= s2_sg_ff;
         s3_den_ff <= s2_den_ff;
      end
   end

   // ---------------- stage 4: signed terms
   logic [NW-1:0] s4_tm_in [LANES][TERMS];
   logic [NW-1:0] tmag;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int t = 0; t < TERMS; t++) begin
            tmag = NW'(s3_pp_ff[l][t][0]) + (NW'(s3_pp_ff[l][t][1]) << CW)
                 + (NW'(s3_pp_ff[l][t][2]) << (2 * CW));
            s4_tm_in[l][t] = s3_sg_ff[l][t] ? (~tmag + NW'(1)) : tmag;
         end
      end
   end

   logic          s4_vld_ff, s4_bad_ff;
   logic [NW-1:0] s4_tm_ff [LANES][TERMS];
   logic [DW-1:0] s4_den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_bad_ff <= s3_bad_ff;
         s4_tm_ff <= s4_tm_in;
         s4_den_ff <= s3_den_ff;
      end
   end

   // ---------------- stage 5: numerator sum
   logic          s5_vld_ff, s5_bad_ff;
   logic [NW-1:0] s5_num_ff [LANES];
   logic [DW-1:0] s5_den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_bad_ff <= s4_bad_ff;
         for (int l = 0; l < LANES; l++) s5_num_ff[l] <= s4_tm_ff[l][0] + s4_tm_ff[l][1];
         s5_den_ff <= s4_den_ff;
      end
   end

   // ---------------- stage 6: numerator magnitude
   logic          s6_vld_ff, s6_bad_ff;
   logic [NW-1:0] s6_mag_ff [LANES];
   logic          s6_neg_ff [LANES];
   logic [DW-1:0] s6_den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_bad_ff <= s5_bad_ff;
         for (int l = 0; l < LANES; l++) begin
            s6_neg_ff[l] <= s5_num_ff[l][NW-1];
            s6_mag_ff[l] <= s5_num_ff[l][NW-1] ? (~s5_num_ff[l] + NW'(1)) : s5_num_ff[l];
         end
         s6_den_ff <= s5_den_ff;
      end
   end

   // ---------------- stage 7: rounding bias, n2 = 2|num| + den
   logic           s7_vld_ff, s7_bad_ff;
   logic [N2W-1:0] s7_n2_ff [LANES];
   logic           s7_neg_ff [LANES];
   logic [D2W-1:0] s7_d2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_bad_ff <= s6_bad_ff;
         for (int l = 0; l < LANES; l++) begin
            s7_n2_ff[l] <= (N2W'(s6_mag_ff[l]) << 1) + N2W'(s6_den_ff);
         end
         s7_neg_ff <= s6_neg_ff;
         s7_d2_ff <= {s6_den_ff, 1'b0};
      end
   end

   // ---------------- divider: stage 0 load, then one quotient bit per stage
   logic           dv_vld_ff [QW+1];
   logic           dv_bad_ff [QW+1];
   logic [D2W-1:0] dv_d2_ff  [QW+1];
   logic [RW-1:0]  dv_r_ff   [QW+1][LANES];
   logic [QW-1:0]  dv_lo_ff  [QW+1][LANES];
   logic [QW-1:0]  dv_q_ff   [QW+1][LANES];
   logic           dv_neg_ff [QW+1][LANES];
   logic           dv_ovf_ff [QW+1][LANES];

   logic [RW-1:0]  dv_r_in  [QW][LANES];
   logic           dv_ge_in [QW][LANES];
   logic [RW:0]    dv_t;

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         for (int l = 0; l < LANES; l++) begin
            dv_t = {dv_r_ff[s][l], dv_lo_ff[s][l][QW-1]};
            dv_ge_in[s][l] = dv_t >= (RW+1)'(dv_d2_ff[s]);
            dv_r_in[s][l] = dv_ge_in[s][l] ? RW'(dv_t - (RW+1)'(dv_d2_ff[s])) : RW'(dv_t);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_bad_ff[0] <= s7_bad_ff;
         dv_d2_ff[0] <= s7_d2_ff;
         for (int l = 0; l < LANES; l++) begin
            dv_ovf_ff[0][l] <= s7_n2_ff[l][N2W-1:QW] >= HW'(s7_d2_ff);
            dv_r_ff[0][l] <= s7_n2_ff[l][QW+RW-1:QW];
            dv_lo_ff[0][l] <= s7_n2_ff[l][QW-1:0];
            dv_q_ff[0][l] <= '0;
            dv_neg_ff[0][l] <= s7_neg_ff[l];
         end
         for (int s = 0; s < QW; s++) begin
            dv_bad_ff[s+1] <= dv_bad_ff[s];
            dv_d2_ff[s+1] <= dv_d2_ff[s];
            for (int l = 0; l < LANES; l++) begin
               dv_r_ff[s+1][l] <= dv_r_in[s][l];
               dv_lo_ff[s+1][l] <= {dv_lo_ff[s][l][QW-2:0], 1'b0};
               dv_q_ff[s+1][l] <= {dv_q_ff[s][l][QW-2:0], dv_ge_in[s][l]};
               dv_neg_ff[s+1][l] <= dv_neg_ff[s][l];
               dv_ovf_ff[s+1][l] <= dv_ovf_ff[s][l];
            end
         end
      end
   end

   // ---------------- output: saturate, sign, depth check
   logic [31:0] res_in [LANES];
   logic [31:0] lim, sel;
   logic        sat_l [LANES];
   logic        sat_any;
   rsp_type     rsp_data_ff;

   always_comb begin
      sat_any = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         lim = dv_neg_ff[QW][l] ? 32'h8000_0000 : 32'h7fff_ffff;
         sat_l[l] = dv_ovf_ff[QW][l] || (dv_q_ff[QW][l] > lim);
         sel = sat_l[l] ? lim : dv_q_ff[QW][l];
         res_in[l] = dv_bad_ff[QW] ? 32'd0 : (dv_neg_ff[QW][l] ? (~sel + 32'd1) : sel);
         sat_any = sat_any | sat_l[l];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.jac_rot_x <= res_in[0];
         rsp_data_ff.jac_rot_y <= res_in[1];
         rsp_data_ff.jac_rot_z <= res_in[2];
         rsp_data_ff.jac_trans_x <= res_in[3];
         rsp_data_ff.jac_trans_y <= res_in[4];
         rsp_data_ff.jac_trans_z <= res_in[5];
         rsp_data_ff.bad_depth <= dv_bad_ff[QW];
         rsp_data_ff.saturated <= !dv_bad_ff[QW] && sat_any;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         for (int s = 0; s <= QW; s++) dv_vld_ff[s] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         dv_vld_ff[0] <= s7_vld_ff;
         for (int s = 0; s < QW; s++) dv_vld_ff[s+1] <= dv_vld_ff[s];
         rsp_valid_ff <= dv_vld_ff[QW];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // a bad-depth beat carries zero entries and no saturation
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_depth |->
         rsp_data.jac_rot_x == 32'sd0 && rsp_data.jac_trans_z == 32'sd0
         && !rsp_data.saturated)
      else $error("bad depth beat with nonzero payload");

   // a held pipeline keeps its in-flight beats
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s7_vld_ff) && $stable(dv_vld_ff[QW]) && rsp_valid)
      else $error("pipeline moved while output stalled");

   // input side stalls only when the output register is full and held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule

// File: bench/tb_photometric_pose_jacobian_row.sv
// Testbench for the photometric pose Jacobian row block.
// A directed table and random beats are checked against a wide-integer predictor or fixed expected rows.
// Depends on ppjr_pkg and photometric_pose_jacobian_row.
module tb_photometric_pose_jacobian_row;
   import ppjr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 41;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      req_type pt;
      bit      typed;
      rsp_type want;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FOCAL_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the focal registers
   logic [31:0] fx_model = FOCAL_RESET;
   logic [31:0] fy_model = FOCAL_RESET;

   rsp_type row_queue[$];
   row_type dir_rows[$];
   int      fails = 0;
   int      quiet_cycles = 0;
   int      send_gap_pct = 0;
   int      stall_pct = 0;
   bit      hold_req = 0;
   int      hold_cnt = 0;

   photometric_pose_jacobian_row dut (.*);

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // expected Jacobian row for one point, exact rational rounded once
   function automatic rsp_type jacobian_row(req_type p);
      logic signed [191:0] x, y, z, gu, gv, fxw, fyw, a, b, den, mag, q, lim, res;
      logic signed [191:0] num[6];
      logic [31:0] ent[6];
      logic [1:0]  lvl;
      bit          sat;
      rsp_type     r;
      r = '0;
      if (p.point_z <= 0) begin
         r.bad_depth = 1'b1;
         return r;
      end
      x = p.point_x;
      y = p.point_y;
      z = p.point_z;
      gu = p.grad_u;
      gv = p.grad_v;
      fxw = {160'b0, fx_model};
      fyw = {160'b0, fy_model};
      a = gu * fxw;
      b = gv * fyw;
      lvl = (p.pyramid_level > LVL_MAX) ? LVL_MAX : p.pyramid_level;
      num[0] = -(a * x * y) - b * (z * z + y * y);
      num[1] = a * (z * z + x * x) + b * x * y;
      num[2] = (b * x - a * y) * z;
      num[3] = (a * z) <<< 16;
      num[4] = (b * z) <<< 16;
      num[5] = -((a * x + b * y) <<< 16);
      den = (z * z) <<< lvl;
      sat = 0;
      for (int i = 0; i < 6; i++) begin
         mag = (num[i] < 0) ? -num[i] : num[i];
         q = (2 * mag + den) / (2 * den);
         lim = (num[i] < 0) ? 192'sh80000000 : 192'sh7FFFFFFF;
         if (q > lim) begin
            q = lim;
            sat = 1;
         end
         res = (num[i] < 0) ? -q : q;
         ent[i] = res[31:0];
      end
      r.jac_rot_x = ent[0];
      r.jac_rot_y = ent[1];
      r.jac_rot_z = ent[2];
      r.jac_trans_x = ent[3];
      r.jac_trans_y = ent[4];
      r.jac_trans_z = ent[5];
      r.saturated = sat;
      return r;
   endfunction

   // random point: mostly plausible geometry, some raw bit patterns
   function automatic req_type random_point();
      req_type p;
      int      sel;
      sel = $urandom_range(99);
      p.point_x = $urandom;
      p.point_y = $urandom;
      p.point_z = $urandom;
      p.grad_u = 16'($urandom);
      p.grad_v = 16'($urandom);
      p.pyramid_level = 2'($urandom);
      if (sel < 70) begin
         p.point_z = $urandom_range(32'h0100_0000, 32'h0000_4000);
         p.point_x = $signed($urandom_range(2 * p.point_z)) - p.point_z;
         p.point_y = $signed($urandom_range(2 * p.point_z)) - p.point_z;
         p.grad_u = 16'(int'($urandom_range(511)) - 256);
         p.grad_v = 16'(int'($urandom_range(511)) - 256);
      end else if (sel < 80) begin
         p.point_z = -$signed($urandom_range(1000));
      end
      return p;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FOCAL_X) fx_model = val;
      else fy_model = val;
   endtask

   // offer one point beat and log its expected row at acceptance
   task automatic send_point(input req_type p, input bit typed, input rsp_type want);
      rsp_type exp_row;
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      exp_row = typed ? want : jacobian_row(p);
      row_queue = {row_queue, exp_row};
   endtask

   // stop offering and let every outstanding row drain
   task automatic drain();
      req_valid <= 1'b0;
      while (row_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                          input logic [15:0] gu, input logic [15:0] gv,
                          input logic [1:0] lvl, input bit typed, input rsp_type want);
      row_type r;
      r.pt.point_x = x;
      r.pt.point_y = y;
      r.pt.point_z = z;
      r.pt.grad_u = gu;
      r.pt.grad_v = gv;
      r.pt.pyramid_level = lvl;
      r.typed = typed;
      r.want = want;
      dir_rows = {dir_rows, r};
   endtask

   // receiver: random stall, plus a long hold-off counted here
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // response checker and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (row_queue.size() == 0) begin
               $error("response beat with nothing expected");
               fails++;
            end else begin
               want = row_queue.pop_front();
               if (rsp_data.jac_rot_x !== want.jac_rot_x) begin
                  $error("jac_rot_x exp %h got %h", want.jac_rot_x, rsp_data.jac_rot_x);
                  fails++;
               end
               if (rsp_data.jac_rot_y !== want.jac_rot_y) begin
                  $error("jac_rot_y exp %h got %h", want.jac_rot_y, rsp_data.jac_rot_y);
                  fails++;
               end
               if (rsp_data.jac_rot_z !== want.jac_rot_z) begin
                  $error("jac_rot_z exp %h got %h", want.jac_rot_z, rsp_data.jac_rot_z);
                  fails++;
               end
               if (rsp_data.jac_trans_x !== want.jac_trans_x) begin
                  $error("jac_trans_x exp %h got %h", want.jac_trans_x, rsp_data.jac_trans_x);
                  fails++;
               end
               if (rsp_data.jac_trans_y !== want.jac_trans_y) begin
                  $error("jac_trans_y exp %h got %h", want.jac_trans_y, rsp_data.jac_trans_y);
                  fails++;
               end
               if (rsp_data.jac_trans_z !== want.jac_trans_z) begin
                  $error("jac_trans_z exp %h got %h", want.jac_trans_z, rsp_data.jac_trans_z);
                  fails++;
               end
               if (rsp_data.bad_depth !== want.bad_depth) begin
                  $error("bad_depth exp %b got %b", want.bad_depth, rsp_data.bad_depth);
                  fails++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated exp %b got %b", want.saturated, rsp_data.saturated);
                  fails++;
               end
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      rsp_type zero_row, bad_row, unit_row;
      logic [31:0] fx_set[6];
      logic [31:0] fy_set[6];
      zero_row = '0;
      bad_row = '0;
      bad_row.bad_depth = 1'b1;
      unit_row = '0;
      unit_row.jac_rot_y = FOCAL_RESET;
      unit_row.jac_trans_x = FOCAL_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset focal lengths
      add_row(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h8000, 2'd0, 1, bad_row);
      add_row(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h1, 16'h1, 2'd1, 1, bad_row);
      add_row(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h7FFF, 2'd3, 1, bad_row);
      add_row(32'h0, 32'h0, 32'h0001_0000, 16'h1, 16'h0, 2'd0, 1, unit_row);
      add_row(32'h0, 32'h0, 32'h0001_0000, 16'h0, 16'h0, 2'd2, 1, zero_row);
      add_row(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 16'h7FFF, 16'h8000, 2'd0, 0, '0);
      add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 16'h7FFF, 16'h7FFF, 2'd0, 0, '0);
      add_row(32'h80000000, 32'h80000000, 32'h1, 16'h8000, 16'h8000, 2'd3, 0, '0);
      add_row(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 16'h7FFF, 2'd1, 0, '0);
      add_row(32'h0, 32'h0, 32'h7FFFFFFF, 16'h1, 16'hFFFF, 2'd3, 0, '0);
      for (int l = 0; l < 4; l++)
         add_row(32'h0003_8000, 32'hFFFC_4000, 32'h0020_0000, 16'd37, -16'sd91, 2'(l), 0, '0);
      add_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 16'h0, 16'h1, 2'd2, 0, '0);
      add_row(32'h0001_8000, 32'h0, 32'h0001_0000, 16'h1, 16'h0, 2'd1, 0, '0);
      foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].want);
      drain();

      // random phases, each with its own focal setting and one of four idling mixes
      fx_set = '{32'h0, 32'hFFFFFFFF, $urandom, FOCAL_RESET, 32'h1, $urandom};
      fy_set = '{32'hFFFFFFFF, 32'h0, $urandom, FOCAL_RESET, 32'h1, $urandom};
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_FOCAL_X, fx_set[ph]);
         csr_write(CSR_FOCAL_Y, fy_set[ph]);
         case (ph % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 57; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 57; end
            default: begin send_gap_pct = 11; stall_pct = 11; end
         endcase
         for (int n = 0; n < 200; n++) begin
            if (ph == 0 && n == 20) hold_req = 1;
            send_point(random_point(), 0, '0);
         end
         drain();
      end

      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
